// ===== rtl/scspmv_pkg.sv =====
package scspmv_pkg;

	// Storage and field widths.
	localparam int DIM_MAX = 1024;
	localparam int ADDR_W = $clog2(DIM_MAX);
	localparam int IDX_W = 11;
	localparam int FUNC_W = 2;
	localparam int XW = 32;
	localparam int YW = 48;
	localparam int FRAC = 16;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 5;
	localparam int REG_IDX_W = PADDR_W - 2;

	// Item selector codes.
	localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TRIPLET = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_ALPHA = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BETA = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOMOG = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_XSCALAR = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DIM = 3'd4;

	// Register reset values.
	localparam logic signed [XW-1:0] ALPHA_RST = 32'sd65536;
	localparam logic [IDX_W-1:0] DIM_RST = 11'd1024;

	// Saturation limits of a y element.
	localparam logic signed [YW-1:0] Y_MAX = {1'b0, {(YW-1){1'b1}}};
	localparam logic signed [YW-1:0] Y_MIN = {1'b1, {(YW-1){1'b0}}};

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
		logic signed [XW-1:0] entry_value;
		logic signed [YW-1:0] y_initial;
	} in_item_t;

	typedef struct packed {
		logic status;
		logic [IDX_W-1:0] result_index;
		logic signed [YW-1:0] y_value;
	} out_item_t;

	// Request to and response from the fixed-point multiply unit.
	typedef struct packed {
		logic start;
		logic signed [YW-1:0] a;
		logic signed [XW-1:0] b;
	} mq_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic signed [YW-1:0] res;
	} mq_rsp_t;

	typedef enum logic [1:0] {
		MQ_IDLE,
		MQ_LO,
		MQ_HI,
		MQ_SUM
	} mq_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_WAIT,
		S_LOAD_MUL,
		S_T_ALPHA,
		S_T_ROW,
		S_T_COL,
		S_RESULT
	} state_t;

	// Clamp a wide signed value to the signed y range.
	function automatic logic signed [YW-1:0] sat_y(input logic signed [63:0] v);
		logic signed [63:0] hi_lim;
		logic signed [63:0] lo_lim;
		hi_lim = 64'(Y_MAX);
		lo_lim = 64'(Y_MIN);
		if (v > hi_lim) begin
			sat_y = Y_MAX;
		end else if (v < lo_lim) begin
			sat_y = Y_MIN;
		end else begin
			sat_y = v[YW-1:0];
		end
	endfunction

endpackage

// ===== rtl/scspmv_mulq.sv =====
module scspmv_mulq (
	input logic clk,
	input logic arst_n,
	input scspmv_pkg::mq_req_t req,
	output scspmv_pkg::mq_rsp_t rsp
);
	import scspmv_pkg::*;

	mq_state_t state_q;
	mq_state_t state_d;
	logic signed [YW-1:0] a_q;
	logic signed [XW-1:0] b_q;
	logic signed [XW:0] op_a;
	logic signed [XW:0] op_b;
	logic signed [2*XW+1:0] prod;
	logic signed [63:0] prod_q;
	logic signed [XW:0] low_q;
	logic signed [63:0] sum;
	logic signed [YW-1:0] res_q;
	logic done_q;

	// Next state: low half product, high half product, then the sum.
	always_comb begin
		state_d = state_q;
		case (state_q)
			MQ_IDLE: begin
				if (req.start) begin
					state_d = MQ_LO;
				end
			end
			MQ_LO: state_d = MQ_HI;
			MQ_HI: state_d = MQ_SUM;
			MQ_SUM: state_d = MQ_IDLE;
			default: state_d = MQ_IDLE;
		endcase
	end

	// Operand selection for the shared multiplier and the response.
	always_comb begin
		op_a = '0;
		case (state_q)
			MQ_LO: op_a = {{(XW+1-FRAC){1'b0}}, a_q[FRAC-1:0]};
			MQ_HI: op_a = {a_q[YW-1], a_q[YW-1:FRAC]};
			default: op_a = '0;
		endcase
		op_b = {b_q[XW-1], b_q};
		rsp.busy = (state_q != MQ_IDLE);
		rsp.done = done_q;
		rsp.res = res_q;
	end

	assign prod = op_a * op_b;
	assign sum = prod_q + 64'(low_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MQ_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == MQ_SUM);
		end
	end

	// Operands are held for the whole pass; the product is always registered.
	always_ff @(posedge clk) begin
		if (state_q == MQ_IDLE && req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		prod_q <= prod[63:0];
		if (state_q == MQ_HI) begin
			low_q <= prod_q[FRAC+XW:FRAC];
		end
		if (state_q == MQ_SUM) begin
			res_q <= sat_y(sum);
		end
	end

endmodule

// ===== rtl/symmetric_coo_spmv_top.sv =====
// Channel | Dir | Handshake                 | Payload
// in      | in  | in_valid / in_stall       | in_item_t
// out     | out | out_valid / out_stall     | out_item_t
// cfg     | in  | psel, penable, pwrite     | alpha, beta, homogeneous, x_scalar, dimension
//
// One item is worked on at a time; the input is stalled until the item's result has been handed to the output register.
// Each fixed-point product passes the low half, high half and sum states of the one shared 33x33 multiplier; an
// off-diagonal triplet needs three of them in series around the read-modify-write of the
// y memory, a diagonal triplet two.
// Reset clears the control state and the configuration registers; x and y memories need no clearing.
// A stalled output holds its transfer while the next item is already taken in.
module symmetric_coo_spmv_top (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [scspmv_pkg::PADDR_W-1:0] paddr,
	input logic [scspmv_pkg::PDATA_W-1:0] pwdata,
	output logic [scspmv_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input scspmv_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output scspmv_pkg::out_item_t out_data
);
	import scspmv_pkg::*;

	// Configuration registers.
	logic signed [XW-1:0] alpha_q;
	logic signed [XW-1:0] beta_q;
	logic homog_q;
	logic signed [XW-1:0] xs_q;
	logic [IDX_W-1:0] dim_q;
	logic cfg_wr;

	// Sequencer and item registers.
	state_t state_q;
	state_t state_d;
	logic accept;
	logic [IDX_W-1:0] lim;
	logic row_ok;
	logic col_ok;
	logic [IDX_W-1:0] in_row_m1;
	logic [IDX_W-1:0] in_col_m1;
	logic [ADDR_W-1:0] in_row_addr;
	logic [ADDR_W-1:0] in_col_addr;
	logic [IDX_W-1:0] row_q;
	logic [ADDR_W-1:0] row_addr_q;
	logic [ADDR_W-1:0] col_addr_q;
	logic diag_q;
	logic signed [YW-1:0] t_q;
	logic signed [XW-1:0] x_sel;

	// Memories and their ports.
	logic signed [XW-1:0] x_mem [DIM_MAX];
	logic signed [YW-1:0] y_mem [DIM_MAX];
	logic signed [XW-1:0] x_rd_q;
	logic signed [YW-1:0] y_rd_q;
	logic x_we;
	logic x_ren;
	logic [ADDR_W-1:0] x_raddr;
	logic y_we;
	logic y_ren;
	logic [ADDR_W-1:0] y_raddr;
	logic [ADDR_W-1:0] y_waddr;
	logic signed [YW-1:0] y_wdata;
	logic signed [YW-1:0] y_sum;

	// Multiply unit and result path.
	mq_req_t mq_req;
	mq_rsp_t mq_rsp;
	out_item_t pend_d;
	out_item_t pend_q;
	logic pend_we;
	out_item_t out_q;
	logic out_valid_q;
	logic out_load;

	// Configuration port: writes land in the access cycle, reads return the register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			beta_q <= '0;
			homog_q <= 1'b0;
			xs_q <= '0;
			dim_q <= DIM_RST;
		end else if (cfg_wr) begin
			case (paddr[PADDR_W-1:2])
				REG_ALPHA: alpha_q <= pwdata;
				REG_BETA: beta_q <= pwdata;
				REG_HOMOG: homog_q <= pwdata[0];
				REG_XSCALAR: xs_q <= pwdata;
				REG_DIM: dim_q <= pwdata[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[PADDR_W-1:2])
			REG_ALPHA: prdata = alpha_q;
			REG_BETA: prdata = beta_q;
			REG_HOMOG: prdata = PDATA_W'(homog_q);
			REG_XSCALAR: prdata = xs_q;
			REG_DIM: prdata = PDATA_W'(dim_q);
			default: prdata = '0;
		endcase
	end

	// Index checks against the active vector length.
	assign accept = in_valid && !in_stall;
	assign lim = (dim_q > IDX_W'(DIM_MAX)) ? IDX_W'(DIM_MAX) : dim_q;
	assign row_ok = (in_data.row_index != '0) && (in_data.row_index <= lim);
	assign col_ok = (in_data.col_index != '0) && (in_data.col_index <= lim);
	assign in_row_m1 = in_data.row_index - IDX_W'(1);
	assign in_col_m1 = in_data.col_index - IDX_W'(1);
	assign in_row_addr = in_row_m1[ADDR_W-1:0];
	assign in_col_addr = in_col_m1[ADDR_W-1:0];

	assign x_sel = homog_q ? xs_q : x_rd_q;
	assign y_sum = sat_y(64'(y_rd_q) + 64'(mq_rsp.res));

	// Next state of the item sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_data.func)
						FUNC_LOAD: state_d = row_ok ? S_LOAD_MUL : S_RESULT;
						FUNC_TRIPLET: state_d = (row_ok && col_ok) ? S_T_ALPHA : S_RESULT;
						FUNC_READ: state_d = row_ok ? S_RD_WAIT : S_RESULT;
						default: state_d = S_RESULT;
					endcase
				end
			end
			S_RD_WAIT: state_d = S_RESULT;
			S_LOAD_MUL: begin
				if (mq_rsp.done) begin
					state_d = S_RESULT;
				end
			end
			S_T_ALPHA: begin
				if (mq_rsp.done) begin
					state_d = S_T_ROW;
				end
			end
			S_T_ROW: begin
				if (mq_rsp.done) begin
					state_d = diag_q ? S_RESULT : S_T_COL;
				end
			end
			S_T_COL: begin
				if (mq_rsp.done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier requests, memory ports and the pending result.
	always_comb begin
		in_stall = (state_q != S_IDLE);
		mq_req = '0;
		x_we = 1'b0;
		x_ren = 1'b0;
		x_raddr = row_addr_q;
		y_we = 1'b0;
		y_ren = 1'b0;
		y_raddr = row_addr_q;
		y_waddr = row_addr_q;
		y_wdata = y_sum;
		pend_d = '0;
		pend_we = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				x_raddr = in_col_addr;
				y_raddr = in_row_addr;
				if (accept) begin
					pend_we = 1'b1;
					case (in_data.func)
						FUNC_LOAD: begin
							pend_d.status = !row_ok;
							x_we = row_ok;
							mq_req.start = row_ok;
							mq_req.a = in_data.y_initial;
							mq_req.b = beta_q;
						end
						FUNC_TRIPLET: begin
							pend_d.status = !(row_ok && col_ok);
							x_ren = row_ok && col_ok;
							mq_req.start = row_ok && col_ok;
							mq_req.a = YW'(alpha_q);
							mq_req.b = in_data.entry_value;
						end
						FUNC_READ: begin
							pend_d.status = !row_ok;
							y_ren = row_ok;
						end
						default: pend_d.status = 1'b0;
					endcase
				end
			end
			S_RD_WAIT: begin
				pend_we = 1'b1;
				pend_d.result_index = row_q;
				pend_d.y_value = y_rd_q;
			end
			S_LOAD_MUL: begin
				y_we = mq_rsp.done;
				y_wdata = mq_rsp.res;
			end
			S_T_ALPHA: begin
				// Row term starts with x[col]; fetch x[row] and y[row] meanwhile.
				x_ren = mq_rsp.done;
				y_ren = mq_rsp.done;
				mq_req.start = mq_rsp.done;
				mq_req.a = mq_rsp.res;
				mq_req.b = x_sel;
			end
			S_T_ROW: begin
				y_we = mq_rsp.done;
				y_raddr = col_addr_q;
				y_ren = mq_rsp.done && !diag_q;
				mq_req.start = mq_rsp.done && !diag_q;
				mq_req.a = t_q;
				mq_req.b = x_sel;
			end
			S_T_COL: begin
				y_we = mq_rsp.done;
				y_waddr = col_addr_q;
			end
			S_RESULT: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item registers and the scaled matrix value alpha*v.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= in_data.row_index;
			row_addr_q <= in_row_addr;
			col_addr_q <= in_col_addr;
			diag_q <= (in_data.row_index == in_data.col_index);
		end
		if (state_q == S_T_ALPHA && mq_rsp.done) begin
			t_q <= mq_rsp.res;
		end
		if (pend_we) begin
			pend_q <= pend_d;
		end
	end

	// x memory: written by loads, read for triplets.
	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[in_row_addr] <= in_data.entry_value;
		end
		if (x_ren) begin
			x_rd_q <= x_mem[x_raddr];
		end
	end

	// y memory: written by loads, read for reads, read-modify-write for triplets, one entry at a time.
	always_ff @(posedge clk) begin
		if (y_we) begin
			y_mem[y_waddr] <= y_wdata;
		end
		if (y_ren) begin
			y_rd_q <= y_mem[y_raddr];
		end
	end

	scspmv_mulq u_mulq (
		.clk(clk),
		.arst_n(arst_n),
		.req(mq_req),
		.rsp(mq_rsp)
	);

	// Output register decouples the result transfer from the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTH
	// The shared multiplier is only started when it is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		mq_req.start |-> !mq_rsp.busy)
		else $error("multiplier started while busy");

	// A finished product always arrives in a state that waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		mq_rsp.done |-> (state_q == S_LOAD_MUL || state_q == S_T_ALPHA ||
			state_q == S_T_ROW || state_q == S_T_COL))
		else $error("product finished with no consumer");

	// After a y update the item has only its column update left or is complete.
	assert property (@(posedge clk) disable iff (!arst_n)
		y_we |=> (state_q == S_T_COL || state_q == S_RESULT))
		else $error("unexpected state after y update");

	// Rejected items carry neither an index nor data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status) |-> (out_q.result_index == '0 && out_q.y_value == '0))
		else $error("rejected item carries data");
`endif

endmodule
